// ===== rtl/core/ppt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared widths, constants and the vector type of the pose point transform
// pipeline.
// ----------------------------------------------------------------------------
package ppt_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int GUARD         = 8;
    localparam int CW            = 32;
    localparam int AW            = 16;
    localparam int VW            = CW + 1;
    localparam int XW            = VW + GUARD + 3;
    localparam int ZW            = CW + 2;
    localparam int KW            = 31;
    localparam int PW            = VW + KW + 1;
    localparam int MUL_SHIFT     = KW - GUARD;
    localparam int RW            = XW - GUARD;
    localparam int SW            = RW + 1;
    localparam int TW            = 30;

    localparam logic [KW-1:0] K_Q31 = 31'd1304065748;

    localparam logic signed [ZW-1:0] HALF_TURN =
        {{(ZW - CW){1'b0}}, 1'b1, {(CW - 1){1'b0}}};
    localparam logic signed [ZW-1:0] QUARTER_TURN =
        {{(ZW - CW + 1){1'b0}}, 1'b1, {(CW - 2){1'b0}}};

    localparam logic [TW-1:0] ATAN_TAB [32] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81,
        30'd41,        30'd20,        30'd10,        30'd5,
        30'd3,         30'd1,         30'd1,         30'd0
    };

    typedef struct packed {
        logic                 mode;
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } ppt_vec_t;

endpackage

// ===== rtl/core/pose_point_transform.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_point_transform
// Rigid 2D transform of a Q16.16 point by a pose, forward or inverse, using
// a pipelined CORDIC rotator with saturated outputs.
// ----------------------------------------------------------------------------
// The block accepts one item per clock unless a stall has filled the pipeline
// back to its input, and returns one result item for each, in order. Each item
// passes the preparation stages (offset subtraction, gain prescale multiply,
// quarter-turn folding), the chain of 16 micro-rotations and the output stages
// for rounding, offset addition and saturation. The micro-rotation chain is the
// deepest part of the pipeline; every stage holds its item on a stall
// and empty stages still take new items while a result waits to be taken.
// ----------------------------------------------------------------------------
module pose_point_transform (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic signed [ppt_pkg::CW-1:0] pose_x,
    input  logic signed [ppt_pkg::CW-1:0] pose_y,
    input  logic signed [ppt_pkg::AW-1:0] pose_angle,
    input  logic signed [ppt_pkg::CW-1:0] point_x,
    input  logic signed [ppt_pkg::CW-1:0] point_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [ppt_pkg::CW-1:0] out_x,
    output logic signed [ppt_pkg::CW-1:0] out_y,
    output logic                          saturated
);
    import ppt_pkg::*;

    logic     prep_valid, prep_ready;
    logic     rot_valid, rot_ready;
    ppt_vec_t prep_data, rot_data;

    ppt_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .pose_x     (pose_x),
        .pose_y     (pose_y),
        .pose_angle (pose_angle),
        .point_x    (point_x),
        .point_y    (point_y),
        .out_valid  (prep_valid),
        .out_ready  (prep_ready),
        .out_data   (prep_data)
    );

    ppt_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (rot_valid),
        .out_ready (rot_ready),
        .out_data  (rot_data)
    );

    ppt_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rot_valid),
        .in_ready  (rot_ready),
        .in_data   (rot_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_x     (out_x),
        .out_y     (out_y),
        .saturated (saturated)
    );

endmodule

// ===== rtl/core/ppt_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_prep
// Input register with offset subtraction in inverse mode, gain prescale
// multiply and quarter-turn folding, as three pipeline stages.
// ----------------------------------------------------------------------------
module ppt_prep (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic signed [ppt_pkg::CW-1:0] pose_x,
    input  logic signed [ppt_pkg::CW-1:0] pose_y,
    input  logic signed [ppt_pkg::AW-1:0] pose_angle,
    input  logic signed [ppt_pkg::CW-1:0] point_x,
    input  logic signed [ppt_pkg::CW-1:0] point_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ppt_pkg::ppt_vec_t             out_data
);
    import ppt_pkg::*;

    logic     s0_valid_reg, s1_valid_reg, s2_valid_reg;
    logic     s0_ready, s1_ready, s2_ready;
    ppt_vec_t s0_data_reg, s1_data_reg, s2_data_reg;
    ppt_vec_t s0_data_next, s1_data_next, s2_data_next;

    logic signed [ZW-1:0] ang_ext;
    logic signed [PW-1:0] prod_x, prod_y;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s0_ready = !s0_valid_reg || s1_ready;
    assign in_ready = s0_ready;

    // Inverse mode subtracts the offset first and turns the other way.
    always_comb
    begin
        ang_ext           = ZW'(pose_angle) <<< (CW - AW);
        s0_data_next.mode = func;
        s0_data_next.px   = pose_x;
        s0_data_next.py   = pose_y;
        s0_data_next.x    = func ? (XW'(point_x) - XW'(pose_x)) : XW'(point_x);
        s0_data_next.y    = func ? (XW'(point_y) - XW'(pose_y)) : XW'(point_y);
        s0_data_next.z    = func ? -ang_ext : ang_ext;
    end

    always_comb
    begin
        prod_x       = $signed(s0_data_reg.x[VW-1:0]) * $signed({1'b0, K_Q31});
        prod_y       = $signed(s0_data_reg.y[VW-1:0]) * $signed({1'b0, K_Q31});
        s1_data_next   = s0_data_reg;
        s1_data_next.x = XW'(prod_x >>> MUL_SHIFT);
        s1_data_next.y = XW'(prod_y >>> MUL_SHIFT);
    end

    // A heading beyond a quarter turn is folded by a half turn and a negation.
    always_comb
    begin
        s2_data_next = s1_data_reg;
        if (s1_data_reg.z > QUARTER_TURN)
        begin
            s2_data_next.z = s1_data_reg.z - HALF_TURN;
            s2_data_next.x = -s1_data_reg.x;
            s2_data_next.y = -s1_data_reg.y;
        end
        else if (s1_data_reg.z < -QUARTER_TURN)
        begin
            s2_data_next.z = s1_data_reg.z + HALF_TURN;
            s2_data_next.x = -s1_data_reg.x;
            s2_data_next.y = -s1_data_reg.y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s0_ready)
            begin
                s0_valid_reg <= in_valid;
            end
            if (s1_ready)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_ready && in_valid)
        begin
            s0_data_reg <= s0_data_next;
        end
        if (s1_ready && s0_valid_reg)
        begin
            s1_data_reg <= s1_data_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

endmodule

// ===== rtl/core/ppt_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_cordic
// Chain of CORDIC micro-rotations in rotation mode, one register stage for
// each micro-rotation.
// ----------------------------------------------------------------------------
module ppt_cordic (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ppt_pkg::ppt_vec_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ppt_pkg::ppt_vec_t out_data
);
    import ppt_pkg::*;

    logic [CORDIC_STAGES-1:0] valid_reg;
    logic [CORDIC_STAGES-1:0] stage_valid;
    logic [CORDIC_STAGES:0]   stage_ready;
    ppt_vec_t                 data_reg  [CORDIC_STAGES];
    ppt_vec_t                 stage_in  [CORDIC_STAGES];
    ppt_vec_t                 data_next [CORDIC_STAGES];

    always_comb
    begin
        stage_ready[CORDIC_STAGES] = out_ready;
        for (int i = CORDIC_STAGES - 1; i >= 0; i--)
        begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i + 1];
        end
    end

    always_comb
    begin
        stage_in[0]    = in_data;
        stage_valid[0] = in_valid;
        for (int i = 1; i < CORDIC_STAGES; i++)
        begin
            stage_in[i]    = data_reg[i - 1];
            stage_valid[i] = valid_reg[i - 1];
        end
    end

    // A zero or positive residual angle rotates in the positive sense.
    always_comb
    begin
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [ZW-1:0] step;
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            dx           = $signed(stage_in[i].y) >>> i;
            dy           = $signed(stage_in[i].x) >>> i;
            step         = $signed(ZW'(ATAN_TAB[5'(i)]));
            data_next[i] = stage_in[i];
            if (!stage_in[i].z[ZW-1])
            begin
                data_next[i].x = stage_in[i].x - dx;
                data_next[i].y = stage_in[i].y + dy;
                data_next[i].z = stage_in[i].z - step;
            end
            else
            begin
                data_next[i].x = stage_in[i].x + dx;
                data_next[i].y = stage_in[i].y - dy;
                data_next[i].z = stage_in[i].z + step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < CORDIC_STAGES; i++)
            begin
                if (stage_ready[i])
                begin
                    valid_reg[i] <= stage_valid[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            if (stage_ready[i] && stage_valid[i])
            begin
                data_reg[i] <= data_next[i];
            end
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[CORDIC_STAGES - 1];
    assign out_data  = data_reg[CORDIC_STAGES - 1];

endmodule

// ===== rtl/core/ppt_post.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppt_post
// Rounding, pose offset addition in forward mode, and saturation into the
// output register.
// ----------------------------------------------------------------------------
module ppt_post (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  ppt_pkg::ppt_vec_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [ppt_pkg::CW-1:0] out_x,
    output logic signed [ppt_pkg::CW-1:0] out_y,
    output logic                          saturated
);
    import ppt_pkg::*;

    localparam logic signed [XW-1:0] ROUND_HALF = XW'(1) <<< (GUARD - 1);
    localparam logic signed [SW-1:0] OUT_MAX    = SW'({1'b0, {(CW - 1){1'b1}}});
    localparam logic signed [SW-1:0] OUT_MIN    = -OUT_MAX - SW'(1);

    logic                 a_valid_reg, b_valid_reg;
    logic                 a_ready, b_ready;
    logic signed [SW-1:0] sum_x_reg, sum_y_reg, sum_x_next, sum_y_next;
    logic signed [RW-1:0] rnd_x, rnd_y;
    logic signed [CW-1:0] out_x_reg, out_y_reg, out_x_next, out_y_next;
    logic                 sat_reg, sat_next;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb
    begin
        rnd_x      = RW'((in_data.x + ROUND_HALF) >>> GUARD);
        rnd_y      = RW'((in_data.y + ROUND_HALF) >>> GUARD);
        sum_x_next = SW'(rnd_x) + (in_data.mode ? SW'(0) : SW'(in_data.px));
        sum_y_next = SW'(rnd_y) + (in_data.mode ? SW'(0) : SW'(in_data.py));
    end

    always_comb
    begin
        sat_next   = 1'b0;
        out_x_next = CW'(sum_x_reg);
        out_y_next = CW'(sum_y_reg);
        if (sum_x_reg > OUT_MAX)
        begin
            out_x_next = CW'(OUT_MAX);
            sat_next   = 1'b1;
        end
        else if (sum_x_reg < OUT_MIN)
        begin
            out_x_next = CW'(OUT_MIN);
            sat_next   = 1'b1;
        end
        if (sum_y_reg > OUT_MAX)
        begin
            out_y_next = CW'(OUT_MAX);
            sat_next   = 1'b1;
        end
        else if (sum_y_reg < OUT_MIN)
        begin
            out_y_next = CW'(OUT_MIN);
            sat_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
        end
        if (b_ready && a_valid_reg)
        begin
            out_x_reg <= out_x_next;
            out_y_reg <= out_y_next;
            sat_reg   <= sat_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign saturated = sat_reg;

endmodule
